// ===== hdl/lota_pkg.sv =====
// ----------------------------------------------------------------------------
// lota_pkg: shared types and constants for the LoRa time-on-air calculator
// Register indexes, the resolved configuration struct, and the reciprocal
// table used for the ceiling division by 4*SF.
// ----------------------------------------------------------------------------
package lota_pkg;

  localparam int unsigned LenW    = 8;   // payload length in bytes
  localparam int unsigned SymW    = 10;  // payload symbol count
  localparam int unsigned AirW    = 32;  // air time in microseconds
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  localparam int unsigned SfW     = 4;
  localparam int unsigned BwW     = 2;
  localparam int unsigned CrW     = 3;
  localparam int unsigned PreW    = 16;
  localparam int unsigned ShiftW  = 4;

  // (8*len + 28 + 16*crc) - 1 fits in 12 bits
  localparam int unsigned NumW    = 12;
  // fixed-point reciprocal of 4*SF, scaled by 2^RecipFrac
  localparam int unsigned RecipFrac = 18;
  localparam int unsigned RecipW    = 14;
  localparam int unsigned ProdW     = NumW + RecipW;
  // ceil term is at most 74
  localparam int unsigned BlkW      = 7;
  // 4*(preamble + symbols) + 17
  localparam int unsigned QuartW    = 19;

  localparam logic [SymW-1:0]   HeaderSymbols = SymW'(8);
  localparam logic [QuartW-1:0] FixedQuarters = QuartW'(17);

  localparam logic [SfW-1:0] SfMin = SfW'(7);
  localparam logic [SfW-1:0] SfMax = SfW'(12);
  localparam logic [BwW-1:0] BwMax = BwW'(2);
  localparam logic [CrW-1:0] CrMin = CrW'(1);
  localparam logic [CrW-1:0] CrMax = CrW'(4);

  typedef enum logic [CfgIdxW-1:0] {
    RegSpreadingFactor = 3'd0,
    RegBandwidthCode   = 3'd1,
    RegCodingRate      = 3'd2,
    RegPreambleSymbols = 3'd3,
    RegCrcEnable       = 3'd4
  } cfg_reg_e;

  // configuration after range clamping
  typedef struct packed {
    logic [SfW-1:0]    sf;
    logic [CrW-1:0]    cr;
    logic [PreW-1:0]   pre;
    logic              crc;
    logic [ShiftW-1:0] air_shift;  // log2 of a quarter symbol in us
  } cfg_t;

  // ceil(2^18 / (4*sf)); exact floor for numerators below 4096
  function automatic logic [RecipW-1:0] recip_of_sf(input logic [SfW-1:0] sf);
    logic [RecipW-1:0] r;
    case (sf)
      4'd7:    r = RecipW'(9363);
      4'd8:    r = RecipW'(8192);
      4'd9:    r = RecipW'(7282);
      4'd10:   r = RecipW'(6554);
      4'd11:   r = RecipW'(5958);
      4'd12:   r = RecipW'(5462);
      default: r = RecipW'(9363);
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/lota_cfg.sv =====
// ----------------------------------------------------------------------------
// lota_cfg: configuration registers
// Holds the five programmable fields and presents them clamped to range.
// ----------------------------------------------------------------------------
module lota_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [lota_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lota_pkg::CfgDatW-1:0]   cfg_data_i,
  output lota_pkg::cfg_t                 cfg_o
);
  import lota_pkg::*;

  logic [SfW-1:0]  sf_q;
  logic [BwW-1:0]  bw_q;
  logic [CrW-1:0]  cr_q;
  logic [PreW-1:0] pre_q;
  logic            crc_q;

  logic [SfW-1:0]  sf_eff;
  logic [BwW-1:0]  bw_eff;
  logic [CrW-1:0]  cr_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_q  <= SfW'(7);
      bw_q  <= BwW'(0);
      cr_q  <= CrW'(3);
      pre_q <= PreW'(8);
      crc_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegSpreadingFactor: sf_q  <= cfg_data_i[SfW-1:0];
        RegBandwidthCode:   bw_q  <= cfg_data_i[BwW-1:0];
        RegCodingRate:      cr_q  <= cfg_data_i[CrW-1:0];
        RegPreambleSymbols: pre_q <= cfg_data_i[PreW-1:0];
        RegCrcEnable:       crc_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sf_eff = sf_q;
    if (sf_q < SfMin) sf_eff = SfMin;
    if (sf_q > SfMax) sf_eff = SfMax;
    bw_eff = (bw_q > BwMax) ? BwMax : bw_q;
    cr_eff = cr_q;
    if (cr_q < CrMin) cr_eff = CrMin;
    if (cr_q > CrMax) cr_eff = CrMax;

    cfg_o.sf        = sf_eff;
    cfg_o.cr        = cr_eff;
    cfg_o.pre       = pre_q;
    cfg_o.crc       = crc_q;
    // quarter symbol = 2^(sf + 1 - bw) us, 6..13
    cfg_o.air_shift = ShiftW'(sf_eff + SfW'(1) - {2'b00, bw_eff});
  end

endmodule

// ===== hdl/lora_time_on_air_top.sv =====
// ----------------------------------------------------------------------------
// lora_time_on_air_top: LoRa frame time-on-air calculator
// Explicit header, no low-data-rate optimization. One result item per
// input item: payload symbol count and total air time in microseconds.
// ----------------------------------------------------------------------------
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, payload_bytes_i        | to block
//  out     | out_valid_o, out_ready_i, payload_symbol_count_o,| from block
//          | air_time_us_o                                  |
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | to block
//
// Four-stage pipeline: one item per cycle sustained while out_ready_i is high;
// the result is registered in stage 4. The stage depth is set by the
// reciprocal multiply (stage 2) and the preamble add plus shift (stage 4).
// Reset clears all stage valid bits and loads the register reset values.
// Each stage holds when the next is full and stalled; bubbles are squeezed
// out, so the input is taken while a result waits if an earlier stage is empty.
// Configuration writes are always taken (cfg_ready_o tied high).
module lora_time_on_air_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lota_pkg::LenW-1:0]      payload_bytes_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lota_pkg::SymW-1:0]      payload_symbol_count_o,
  output logic [lota_pkg::AirW-1:0]      air_time_us_o,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lota_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lota_pkg::CfgDatW-1:0]   cfg_data_i
);
  import lota_pkg::*;

  cfg_t cfg;

  lota_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign cfg_ready_o = 1'b1;

  // stage valid bits and per-stage ready (bubble collapsing)
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: ceiling numerator.
  // ceil((pos - 4sf) / 4sf) == floor((pos - 1) / 4sf), and that floor is
  // zero whenever pos <= 4sf, so no compare is needed.
  logic [NumW-1:0] num_d, num_q;

  assign num_d = NumW'({payload_bytes_i, 3'b000}) + NumW'(28)
               + (cfg.crc ? NumW'(16) : NumW'(0)) - NumW'(1);

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) num_q <= num_d;
  end

  // Stage 2: divide by 4*sf through the reciprocal table
  logic [ProdW-1:0] prod;
  logic [BlkW-1:0]  blk_d, blk_q;

  assign prod  = ProdW'(num_q) * ProdW'(recip_of_sf(cfg.sf));
  assign blk_d = prod[RecipFrac +: BlkW];

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) blk_q <= blk_d;
  end

  // Stage 3: symbol count = 8 + blocks * (cr + 4)
  logic [SymW-1:0] nsym_d, nsym3_q;

  assign nsym_d = HeaderSymbols
                + SymW'(SymW'(blk_q) * SymW'({1'b0, cfg.cr} + 4'd4));

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) nsym3_q <= nsym_d;
  end

  // Stage 4: quarters of a symbol, scaled to microseconds
  logic [QuartW-1:0] quarters;
  logic [AirW-1:0]   air_d, air_q;
  logic [SymW-1:0]   nsym4_q;

  assign quarters = QuartW'({(QuartW-2)'(cfg.pre) + (QuartW-2)'(nsym3_q), 2'b00})
                  + FixedQuarters;
  assign air_d    = AirW'(quarters) << cfg.air_shift;

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      air_q   <= air_d;
      nsym4_q <= nsym3_q;
    end
  end

  assign out_valid_o            = v4_q;
  assign payload_symbol_count_o = nsym4_q;
  assign air_time_us_o          = air_q;

`ifndef SYNTHESIS
  // an empty front stage never blocks the input
  a_front_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> in_ready_o)
    else $error("input blocked with stage 1 empty");

  // an item leaving stage 1 lands in stage 2
  a_s1_to_s2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && rdy2) |=> v2_q)
    else $error("item lost between stage 1 and stage 2");

  // the header alone always gives at least eight symbols
  a_min_symbols : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (payload_symbol_count_o >= HeaderSymbols))
    else $error("symbol count below header minimum");

  // a quarter symbol is at least 64 us
  a_air_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (air_time_us_o[5:0] == 6'd0))
    else $error("air time not a multiple of the shortest quarter symbol");
`endif

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: regression for the LoRa time-on-air calculator
// Drives payload lengths through the valid/ready input under several
// configurations, predicts symbol count and air time for every accepted
// item, and checks each result item in order. Random gaps on both sides,
// one long output hold-off and mid-phase drains stress the pipeline.
// ----------------------------------------------------------------------------
module testbench;
  import lota_pkg::*;

  localparam int CycleLimit = 400000;  // watchdog
  localparam int QuietGap   = 8;       // idle cycles before a register write
  localparam int TailCycles = 16;      // wait after the last result
  localparam int LongHold   = 300;     // output hold-off, fills the pipeline
  localparam int PhaseItems = 240;

  // index that decodes to no register, write must be ignored
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  typedef enum logic [1:0] {
    StimItem,
    StimCfg,
    StimDrain,
    StimMode
  } stim_kind_e;

  typedef struct {
    stim_kind_e           kind;
    logic [LenW-1:0]      len;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDatW-1:0]   data;
    int                   send_pct;
    int                   recv_pct;
    bit                   long_hold;
  } stim_t;

  typedef struct {
    logic [SymW-1:0] sym;
    logic [AirW-1:0] air;
  } air_result_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  // DUT ports, all inputs known from time zero
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic [LenW-1:0]     payload_bytes_i = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [SymW-1:0]     payload_symbol_count_o;
  logic [AirW-1:0]     air_time_us_o;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [CfgDatW-1:0]  cfg_data_i      = '0;

  lora_time_on_air_top i_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .payload_bytes_i        (payload_bytes_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .payload_symbol_count_o (payload_symbol_count_o),
    .air_time_us_o          (air_time_us_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i)
  );

  // bench-side copy of the registers, raw widths as written
  logic [SfW-1:0]  model_sf;
  logic [BwW-1:0]  model_bw;
  logic [CrW-1:0]  model_cr;
  logic [PreW-1:0] model_pre;
  logic            model_crc;

  stim_t       stim_q[$];        // pending items, writes and phase marks
  air_result_t air_expect_q[$];  // predicted results, oldest first

  // issued, checked, hold and quiet counters use NBAs so the driver and monitor see stable values
  int unsigned issued_cnt  = 0;
  int unsigned checked_cnt = 0;
  int unsigned hold_seq    = 0;
  int          recv_stall_pct = 0;
  int          send_idle_pct  = 0;
  int          quiet_cnt      = 0;
  int          fail_cnt       = 0;
  int          cycle_cnt      = 0;

  // Symbol count and air time for one length under the current registers.
  // Out-of-range register values are clamped the same way the block does.
  function automatic air_result_t predict_air_time(input logic [LenW-1:0] len);
    int unsigned sf, bw, cr, pos, neg, blocks, nsym;
    logic [63:0] quarters;
    air_result_t r;
    sf  = (model_sf < SfMin) ? SfMin : (model_sf > SfMax) ? SfMax : model_sf;
    bw  = (model_bw > BwMax) ? BwMax : model_bw;
    cr  = (model_cr < CrMin) ? CrMin : (model_cr > CrMax) ? CrMax : model_cr;
    pos = 8 * int'(len) + 28 + 16 * int'(model_crc);
    neg = 4 * sf;
    nsym = HeaderSymbols;
    // numerator zero or negative: no payload blocks beyond the header
    if (pos > neg) begin
      blocks = (pos - neg + neg - 1) / neg;
      nsym  += blocks * (cr + 4);
    end
    quarters = 64'(4 * (int'(model_pre) + nsym)) + 64'(FixedQuarters);
    r.sym = SymW'(nsym);
    r.air = AirW'(quarters << (sf + 1 - bw));
    return r;
  endfunction

  function automatic void apply_cfg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDatW-1:0] data);
    case (idx)
      RegSpreadingFactor: model_sf  = data[SfW-1:0];
      RegBandwidthCode:   model_bw  = data[BwW-1:0];
      RegCodingRate:      model_cr  = data[CrW-1:0];
      RegPreambleSymbols: model_pre = data[PreW-1:0];
      RegCrcEnable:       model_crc = data[0];
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: pops one stimulus entry at a time. Items go out with random gaps,
  // register writes and drain marks wait until the pipeline has emptied and
  // stayed quiet. One NBA per signal per edge, so a valid that carries
  // straight into the next item never drops.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : driver
    stim_t head;
    logic  nxt_in_valid;
    logic  nxt_cfg_valid;
    bit    quiet;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      cfg_valid_i <= 1'b0;
      issued_cnt  <= 0;
      quiet_cnt   <= 0;
      model_sf    = 4'd7;
      model_bw    = 2'd0;
      model_cr    = 3'd3;
      model_pre   = 16'd8;
      model_crc   = 1'b1;
    end else begin
      nxt_in_valid  = in_valid_i;
      nxt_cfg_valid = cfg_valid_i;
      if (in_valid_i && in_ready_o) begin
        air_expect_q.push_back(predict_air_time(payload_bytes_i));
        issued_cnt  <= issued_cnt + 1;
        nxt_in_valid = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        apply_cfg(cfg_index_i, cfg_data_i);
        nxt_cfg_valid = 1'b0;
      end
      // every item yields a result, so matching counts mean nothing in flight
      quiet = (quiet_cnt >= QuietGap);
      if (issued_cnt == checked_cnt && !in_valid_i && !cfg_valid_i) begin
        quiet_cnt <= quiet_cnt + 1;
      end else begin
        quiet_cnt <= 0;
      end
      if (!nxt_in_valid && !nxt_cfg_valid && stim_q.size() > 0) begin
        head = stim_q[0];
        case (head.kind)
          StimMode: begin
            send_idle_pct   = head.send_pct;
            recv_stall_pct <= head.recv_pct;
            if (head.long_hold) hold_seq <= hold_seq + 1;
            void'(stim_q.pop_front());
          end
          StimDrain: begin
            if (quiet) void'(stim_q.pop_front());
          end
          StimCfg: begin
            if (quiet) begin
              void'(stim_q.pop_front());
              nxt_cfg_valid = 1'b1;
              cfg_index_i  <= head.idx;
              cfg_data_i   <= head.data;
            end
          end
          StimItem: begin
            if ($urandom_range(99) >= send_idle_pct) begin
              void'(stim_q.pop_front());
              nxt_in_valid     = 1'b1;
              payload_bytes_i <= head.len;
            end
          end
          default: ;
        endcase
      end
      in_valid_i  <= nxt_in_valid;
      cfg_valid_i <= nxt_cfg_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each accepted result item against the oldest prediction
  // and drives out_ready_i, with random stalls or a long counted hold-off.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    air_result_t want;
    int          hold_left;
    int unsigned hold_seen;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      checked_cnt <= 0;
      hold_left    = 0;
      hold_seen    = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (issued_cnt == checked_cnt) begin
          $error("result item with no expectation: symbols %0d air %0d",
                 payload_symbol_count_o, air_time_us_o);
          fail_cnt++;
        end else begin
          want = air_expect_q.pop_front();
          checked_cnt <= checked_cnt + 1;
          if (payload_symbol_count_o !== want.sym) begin
            $error("payload_symbol_count: expected %0d actual %0d",
                   want.sym, payload_symbol_count_o);
            fail_cnt++;
          end
          if (air_time_us_o !== want.air) begin
            $error("air_time_us: expected %0d actual %0d", want.air, air_time_us_o);
            fail_cnt++;
          end
        end
      end
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // stimulus builders
  task automatic add_item(input logic [LenW-1:0] len);
    stim_t s;
    s = '{kind: StimItem, len: len, idx: '0, data: '0,
          send_pct: 0, recv_pct: 0, long_hold: 1'b0};
    stim_q.push_back(s);
  endtask

  task automatic add_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    stim_t s;
    s = '{kind: StimCfg, len: '0, idx: idx, data: data,
          send_pct: 0, recv_pct: 0, long_hold: 1'b0};
    stim_q.push_back(s);
  endtask

  task automatic add_mode(input int send_pct, input int recv_pct, input bit long_hold);
    stim_t s;
    s = '{kind: StimMode, len: '0, idx: '0, data: '0,
          send_pct: send_pct, recv_pct: recv_pct, long_hold: long_hold};
    stim_q.push_back(s);
  endtask

  task automatic add_drain();
    stim_t s;
    s = '{kind: StimDrain, len: '0, idx: '0, data: '0,
          send_pct: 0, recv_pct: 0, long_hold: 1'b0};
    stim_q.push_back(s);
  endtask

  // one register value: mostly legal, sometimes a raw 16-bit word
  function automatic logic [CfgDatW-1:0] pick_value(input int lo, input int hi);
    if ($urandom_range(3) == 0) return CfgDatW'($urandom());
    return CfgDatW'($urandom_range(hi, lo));
  endfunction

  // watchdog
  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus plan and end of run
  // --------------------------------------------------------------------------
  initial begin : plan
    int send_pct [4];
    int recv_pct [4];
    int m;

    send_pct = '{0, 52, 0, 33};
    recv_pct = '{0, 0, 52, 33};

    // directed, reset configuration: extremes and alternating bit patterns
    add_mode(0, 0, 1'b0);
    add_item(8'd0);
    add_item(8'd255);
    add_item(8'd1);
    add_item(8'h55);
    add_item(8'hAA);
    add_item(8'h0F);
    add_item(8'hF0);

    // SF12, 500 kHz, CR 4/8, longest preamble, no CRC;
    // the shortest lengths leave the numerator below zero
    add_drain();
    add_cfg(RegSpreadingFactor, 16'd12);
    add_cfg(RegBandwidthCode,   16'd2);
    add_cfg(RegCodingRate,      16'd4);
    add_cfg(RegPreambleSymbols, 16'hFFFF);
    add_cfg(RegCrcEnable,       16'd0);
    add_item(8'd0);
    add_item(8'd2);
    add_item(8'd3);
    add_item(8'd255);

    // SF9 without CRC: length 1 gives a numerator of exactly zero
    add_cfg(RegSpreadingFactor, 16'd9);
    add_cfg(RegCodingRate,      16'd1);
    add_cfg(RegPreambleSymbols, 16'd0);
    add_item(8'd1);
    add_item(8'd2);

    // clamped settings: SF below range, bandwidth code 3, coding rate 0;
    // upper bits of the data word must be dropped
    add_cfg(RegSpreadingFactor, 16'hFFF0);
    add_cfg(RegBandwidthCode,   16'd3);
    add_cfg(RegCodingRate,      16'd0);
    add_item(8'd0);
    add_item(8'd255);

    // SF above range, coding rate above range, CRC on, write to no register
    add_cfg(RegSpreadingFactor, 16'd15);
    add_cfg(RegCodingRate,      16'd7);
    add_cfg(RegCrcEnable,       16'hFFFF);
    add_cfg(RegUnused,          16'hFFFF);
    add_item(8'd128);
    add_item(8'd255);
    add_item(8'd77);

    // random phases; the first two pin the register extremes
    for (int p = 0; p < 8; p++) begin
      add_drain();
      if (p == 0) begin
        add_cfg(RegSpreadingFactor, 16'd7);
        add_cfg(RegBandwidthCode,   16'd0);
        add_cfg(RegCodingRate,      16'd1);
        add_cfg(RegPreambleSymbols, 16'd0);
        add_cfg(RegCrcEnable,       16'd0);
      end else if (p == 1) begin
        add_cfg(RegSpreadingFactor, 16'd12);
        add_cfg(RegBandwidthCode,   16'd2);
        add_cfg(RegCodingRate,      16'd4);
        add_cfg(RegPreambleSymbols, 16'd65535);
        add_cfg(RegCrcEnable,       16'd1);
      end else begin
        add_cfg(RegSpreadingFactor, pick_value(7, 12));
        add_cfg(RegBandwidthCode,   pick_value(0, 2));
        add_cfg(RegCodingRate,      pick_value(1, 4));
        add_cfg(RegPreambleSymbols, CfgDatW'($urandom()));
        add_cfg(RegCrcEnable,       pick_value(0, 1));
      end
      m = p % 4;
      // phase 4: output held off while the sender keeps pushing
      add_mode(send_pct[m], recv_pct[m], p == 4);
      for (int i = 0; i < PhaseItems; i++) begin
        // sender pause until the pipeline has drained
        if (i == PhaseItems / 2) add_drain();
        add_item(LenW'($urandom_range(255)));
      end
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // sample on the falling edge, away from the driver and monitor updates
    do begin
      @(negedge clk_i);
    end while (stim_q.size() != 0 || in_valid_i || cfg_valid_i ||
               issued_cnt != checked_cnt);
    repeat (TailCycles) @(negedge clk_i);

    if (air_expect_q.size() != 0) begin
      $error("%0d expected result items never arrived", air_expect_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
